// ===== rtl/core/ffsa_pkg.sv =====
`timescale 1ns / 1ps

package ffsa_pkg;

	localparam int SEG_N  = 32;
	localparam int IDX_W  = $clog2(SEG_N);
	localparam int CNT_W  = IDX_W + 1;
	localparam int ADDR_W = 16;
	localparam int CMD_W  = 3;

	localparam logic [ADDR_W-1:0] REGION_RESET = ADDR_W'(4096);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_SHRINK = 3'd2,
		CMD_EXPAND = 3'd3,
		CMD_CLEAN  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_NO_SPACE  = 2'd1,
		RS_NOT_FOUND = 2'd2,
		RS_BAD       = 2'd3
	} res_st_t;

	typedef enum logic [1:0] {
		SS_UNALLOC  = 2'd0,
		SS_RESERVED = 2'd1,
		SS_FREED    = 2'd2,
		SS_AVAIL    = 2'd3
	} seg_st_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,
		OP_NEXT,
		OP_FAIL,
		OP_ALLOC_EXACT,
		OP_ALLOC_SPLIT,
		OP_FREE,
		OP_FOUND,
		OP_SHR_GROW,
		OP_SHR_INS,
		OP_EXP_CLOSE,
		OP_EXP_TRIM,
		OP_MARK,
		OP_MERGE_INIT,
		OP_MERGE,
		OP_MERGE_SKIP,
		OP_LOAD_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ALLOC,
		S_FIND,
		S_SHRINK,
		S_EXPAND,
		S_MARK,
		S_MERGE_INIT,
		S_MERGE,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		dp_op_t  op;
		res_st_t fail_st;
	} ctl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             size_zero;
		logic             in_range;
		logic             row_free;
		logic             row_res;
		logic             addr_hit;
		logic             len_ge;
		logic             len_eq;
		logic             full;
		logic             next_short;
		logic             next_eq;
		logic             acc_free;
		logic             out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/core/ffsa_dp.sv =====
`timescale 1ns / 1ps

module ffsa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ffsa_pkg::ADDR_W-1:0]    cfg_wdata,
	input  logic [ffsa_pkg::CMD_W-1:0]     cmd,
	input  logic [ffsa_pkg::ADDR_W-1:0]    seg_addr,
	input  logic [ffsa_pkg::ADDR_W-1:0]    req_size,
	input  ffsa_pkg::ctl_cmd_t             ctl,
	output ffsa_pkg::dp_stat_t             stat,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [ffsa_pkg::ADDR_W-1:0]    result_addr,
	output logic [1:0]                     status,
	output logic [ffsa_pkg::ADDR_W-1:0]    used_total
);

	localparam int N  = ffsa_pkg::SEG_N;
	localparam int AW = ffsa_pkg::ADDR_W;
	localparam int IW = ffsa_pkg::IDX_W;
	localparam int CW = ffsa_pkg::CNT_W;

	// segment table rows
	logic [AW-1:0]        off_q [N];
	logic [AW-1:0]        len_q [N];
	ffsa_pkg::seg_st_t    st_q  [N];
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        used_q;

	// command and scan registers
	logic [ffsa_pkg::CMD_W-1:0] cmd_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        size_q;
	logic [CW-1:0]        idx_q;
	logic [IW-1:0]        k_q;
	logic [AW-1:0]        delta_q;
	logic [AW-1:0]        acc_len_q;
	logic                 acc_free_q;

	// result register
	logic [AW-1:0]        res_addr_q;
	ffsa_pkg::res_st_t    res_st_q;
	logic                 out_valid_q;
	logic [AW-1:0]        out_addr_q;
	logic [1:0]           out_st_q;
	logic [AW-1:0]        out_used_q;

	logic [IW-1:0]        ri;
	logic [IW-1:0]        ri_prev;
	logic [IW-1:0]        ri_next;
	logic [AW-1:0]        rd_off;
	logic [AW-1:0]        rd_len;
	ffsa_pkg::seg_st_t    rd_st;
	logic                 rd_free;
	logic [AW-1:0]        delta_d;

	assign ri      = idx_q[IW-1:0];
	assign ri_prev = ri - IW'(1);
	assign ri_next = ri + IW'(1);
	assign rd_off  = off_q[ri];
	assign rd_len  = len_q[ri];
	assign rd_st   = st_q[ri];
	assign rd_free = (rd_st == ffsa_pkg::SS_UNALLOC) || (rd_st == ffsa_pkg::SS_AVAIL);
	assign delta_d = (cmd_q == ffsa_pkg::CMD_SHRINK) ? (rd_len - size_q) : (size_q - rd_len);

	always_comb begin
		stat.cmd        = cmd_q;
		stat.size_zero  = (size_q == '0);
		stat.in_range   = (idx_q < cnt_q);
		stat.row_free   = rd_free;
		stat.row_res    = (rd_st == ffsa_pkg::SS_RESERVED);
		stat.addr_hit   = (rd_off == addr_q);
		stat.len_ge     = (rd_len >= size_q);
		stat.len_eq     = (rd_len == size_q);
		stat.full       = (cnt_q == CW'(N));
		stat.next_short = (rd_len < delta_q);
		stat.next_eq    = (rd_len == delta_q);
		stat.acc_free   = acc_free_q;
		stat.out_busy   = out_valid_q && out_stall;
	end

	// table, counts and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < N; j++) begin
				off_q[j] <= '0;
				len_q[j] <= '0;
				st_q[j]  <= ffsa_pkg::SS_UNALLOC;
			end
			len_q[0]   <= ffsa_pkg::REGION_RESET;
			cnt_q      <= CW'(1);
			used_q     <= '0;
			idx_q      <= '0;
			acc_free_q <= 1'b0;
		end else if (cfg_we) begin
			off_q[0] <= '0;
			len_q[0] <= cfg_wdata;
			st_q[0]  <= ffsa_pkg::SS_UNALLOC;
			cnt_q    <= CW'(1);
			used_q   <= '0;
		end else begin
			unique case (ctl.op)
				ffsa_pkg::OP_START: idx_q <= '0;
				ffsa_pkg::OP_NEXT: idx_q <= idx_q + CW'(1);
				ffsa_pkg::OP_ALLOC_EXACT: begin
					st_q[ri] <= ffsa_pkg::SS_RESERVED;
					used_q   <= used_q + size_q;
				end
				ffsa_pkg::OP_ALLOC_SPLIT: begin
					// open a slot after the hit row for the remainder
					for (int j = 2; j < N; j++) begin
						if (CW'(j) > idx_q + CW'(1)) begin
							off_q[j] <= off_q[j-1];
							len_q[j] <= len_q[j-1];
							st_q[j]  <= st_q[j-1];
						end
					end
					off_q[ri_next] <= rd_off + size_q;
					len_q[ri_next] <= rd_len - size_q;
					st_q[ri_next]  <= ffsa_pkg::SS_UNALLOC;
					len_q[ri]      <= size_q;
					st_q[ri]       <= ffsa_pkg::SS_RESERVED;
					cnt_q          <= cnt_q + CW'(1);
					used_q         <= used_q + size_q;
				end
				ffsa_pkg::OP_FREE: begin
					st_q[ri] <= ffsa_pkg::SS_FREED;
					used_q   <= used_q - rd_len;
				end
				ffsa_pkg::OP_FOUND: begin
					k_q     <= ri;
					delta_q <= delta_d;
					idx_q   <= idx_q + CW'(1);
				end
				ffsa_pkg::OP_SHR_GROW: begin
					off_q[ri]  <= rd_off - delta_q;
					len_q[ri]  <= rd_len + delta_q;
					len_q[k_q] <= size_q;
					used_q     <= used_q - delta_q;
				end
				ffsa_pkg::OP_SHR_INS: begin
					for (int j = 1; j < N; j++) begin
						if (CW'(j) > idx_q) begin
							off_q[j] <= off_q[j-1];
							len_q[j] <= len_q[j-1];
							st_q[j]  <= st_q[j-1];
						end
					end
					off_q[ri]  <= res_addr_q + size_q;
					len_q[ri]  <= delta_q;
					st_q[ri]   <= ffsa_pkg::SS_FREED;
					len_q[k_q] <= size_q;
					cnt_q      <= cnt_q + CW'(1);
					used_q     <= used_q - delta_q;
				end
				ffsa_pkg::OP_EXP_CLOSE: begin
					for (int j = 0; j < N - 1; j++) begin
						if (CW'(j) >= idx_q) begin
							off_q[j] <= off_q[j+1];
							len_q[j] <= len_q[j+1];
							st_q[j]  <= st_q[j+1];
						end
					end
					len_q[k_q] <= size_q;
					cnt_q      <= cnt_q - CW'(1);
					used_q     <= used_q + delta_q;
				end
				ffsa_pkg::OP_EXP_TRIM: begin
					off_q[ri]  <= rd_off + delta_q;
					len_q[ri]  <= rd_len - delta_q;
					len_q[k_q] <= size_q;
					used_q     <= used_q + delta_q;
				end
				ffsa_pkg::OP_MARK: begin
					for (int j = 0; j < N; j++) begin
						if (st_q[j] == ffsa_pkg::SS_FREED) begin
							st_q[j] <= ffsa_pkg::SS_AVAIL;
						end
					end
				end
				ffsa_pkg::OP_MERGE_INIT: begin
					acc_len_q  <= rd_len;
					acc_free_q <= rd_free;
					idx_q      <= idx_q + CW'(1);
				end
				ffsa_pkg::OP_MERGE: begin
					// fold the current row into its left neighbor
					for (int j = 0; j < N - 1; j++) begin
						if (CW'(j) >= idx_q) begin
							off_q[j] <= off_q[j+1];
							len_q[j] <= len_q[j+1];
							st_q[j]  <= st_q[j+1];
						end
					end
					len_q[ri_prev] <= acc_len_q + rd_len;
					acc_len_q      <= acc_len_q + rd_len;
					cnt_q          <= cnt_q - CW'(1);
				end
				ffsa_pkg::OP_MERGE_SKIP: begin
					acc_len_q  <= rd_len;
					acc_free_q <= rd_free;
					idx_q      <= idx_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// command capture and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_st_q    <= ffsa_pkg::RS_OK;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctl.op)
				ffsa_pkg::OP_START: begin
					cmd_q  <= cmd;
					addr_q <= seg_addr;
					size_q <= req_size;
				end
				ffsa_pkg::OP_FAIL: begin
					res_addr_q <= '0;
					res_st_q   <= ctl.fail_st;
				end
				ffsa_pkg::OP_ALLOC_EXACT, ffsa_pkg::OP_ALLOC_SPLIT,
				ffsa_pkg::OP_FREE, ffsa_pkg::OP_FOUND: begin
					res_addr_q <= rd_off;
					res_st_q   <= ffsa_pkg::RS_OK;
				end
				ffsa_pkg::OP_MERGE_INIT: begin
					res_addr_q <= '0;
					res_st_q   <= ffsa_pkg::RS_OK;
				end
				ffsa_pkg::OP_LOAD_OUT: begin
					out_valid_q <= 1'b1;
					out_addr_q  <= res_addr_q;
					out_st_q    <= res_st_q;
					out_used_q  <= used_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_addr = out_addr_q;
	assign status      = out_st_q;
	assign used_total  = out_used_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CW'(N)))
		else $error("segment count out of range");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == ffsa_pkg::OP_FAIL) |=> (res_addr_q == '0) && (res_st_q != ffsa_pkg::RS_OK))
		else $error("failed command left an address");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == ffsa_pkg::OP_LOAD_OUT) |=> out_valid_q && (out_used_q == $past(used_q)))
		else $error("result beat not presented");

endmodule

// ===== rtl/core/ffsa_ctl.sv =====
`timescale 1ns / 1ps

module ffsa_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ffsa_pkg::dp_stat_t  stat,
	output ffsa_pkg::ctl_cmd_t  ctl
);

	ffsa_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffsa_pkg::S_IDLE: if (in_valid) state_d = ffsa_pkg::S_DISPATCH;
			ffsa_pkg::S_DISPATCH: begin
				unique case (stat.cmd)
					ffsa_pkg::CMD_ALLOC:
						state_d = stat.size_zero ? ffsa_pkg::S_DONE : ffsa_pkg::S_ALLOC;
					ffsa_pkg::CMD_FREE, ffsa_pkg::CMD_SHRINK, ffsa_pkg::CMD_EXPAND:
						state_d = ffsa_pkg::S_FIND;
					ffsa_pkg::CMD_CLEAN: state_d = ffsa_pkg::S_MARK;
					default: state_d = ffsa_pkg::S_DONE;
				endcase
			end
			ffsa_pkg::S_ALLOC: begin
				if (!stat.in_range || (stat.row_free && stat.len_ge)) begin
					state_d = ffsa_pkg::S_DONE;
				end
			end
			ffsa_pkg::S_FIND: begin
				priority if (!stat.in_range) begin
					state_d = ffsa_pkg::S_DONE;
				end else if (stat.row_res && stat.addr_hit) begin
					state_d = ffsa_pkg::S_DONE;
					if (stat.cmd == ffsa_pkg::CMD_SHRINK && !stat.size_zero
					    && stat.len_ge && !stat.len_eq) begin
						state_d = ffsa_pkg::S_SHRINK;
					end
					if (stat.cmd == ffsa_pkg::CMD_EXPAND && !stat.size_zero && !stat.len_ge) begin
						state_d = ffsa_pkg::S_EXPAND;
					end
				end else begin
					state_d = state_q;
				end
			end
			ffsa_pkg::S_SHRINK, ffsa_pkg::S_EXPAND: state_d = ffsa_pkg::S_DONE;
			ffsa_pkg::S_MARK:       state_d = ffsa_pkg::S_MERGE_INIT;
			ffsa_pkg::S_MERGE_INIT: state_d = ffsa_pkg::S_MERGE;
			ffsa_pkg::S_MERGE:      if (!stat.in_range) state_d = ffsa_pkg::S_DONE;
			ffsa_pkg::S_DONE:       if (!stat.out_busy) state_d = ffsa_pkg::S_IDLE;
			default:                state_d = ffsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.op      = ffsa_pkg::OP_NONE;
		ctl.fail_st = ffsa_pkg::RS_BAD;
		in_stall    = (state_q != ffsa_pkg::S_IDLE);
		unique case (state_q)
			ffsa_pkg::S_IDLE: if (in_valid) ctl.op = ffsa_pkg::OP_START;
			ffsa_pkg::S_DISPATCH: begin
				unique case (stat.cmd)
					ffsa_pkg::CMD_ALLOC: if (stat.size_zero) ctl.op = ffsa_pkg::OP_FAIL;
					ffsa_pkg::CMD_FREE, ffsa_pkg::CMD_SHRINK,
					ffsa_pkg::CMD_EXPAND, ffsa_pkg::CMD_CLEAN: ctl.op = ffsa_pkg::OP_NONE;
					default: ctl.op = ffsa_pkg::OP_FAIL;
				endcase
			end
			ffsa_pkg::S_ALLOC: begin
				priority if (!stat.in_range) begin
					ctl.op      = ffsa_pkg::OP_FAIL;
					ctl.fail_st = ffsa_pkg::RS_NO_SPACE;
				end else if (stat.row_free && stat.len_ge) begin
					priority if (stat.len_eq) ctl.op = ffsa_pkg::OP_ALLOC_EXACT;
					else if (stat.full)       ctl.op = ffsa_pkg::OP_FAIL;
					else                      ctl.op = ffsa_pkg::OP_ALLOC_SPLIT;
				end else begin
					ctl.op = ffsa_pkg::OP_NEXT;
				end
			end
			ffsa_pkg::S_FIND: begin
				priority if (!stat.in_range) begin
					ctl.op      = ffsa_pkg::OP_FAIL;
					ctl.fail_st = ffsa_pkg::RS_NOT_FOUND;
				end else if (stat.row_res && stat.addr_hit) begin
					priority if (stat.cmd == ffsa_pkg::CMD_FREE) begin
						ctl.op = ffsa_pkg::OP_FREE;
					end else if (stat.cmd == ffsa_pkg::CMD_SHRINK) begin
						ctl.op = (stat.size_zero || !stat.len_ge)
							? ffsa_pkg::OP_FAIL : ffsa_pkg::OP_FOUND;
					end else begin
						ctl.op = (stat.size_zero || (stat.len_ge && !stat.len_eq))
							? ffsa_pkg::OP_FAIL : ffsa_pkg::OP_FOUND;
					end
				end else begin
					ctl.op = ffsa_pkg::OP_NEXT;
				end
			end
			ffsa_pkg::S_SHRINK: begin
				priority if (stat.in_range && stat.row_free) ctl.op = ffsa_pkg::OP_SHR_GROW;
				else if (stat.full)                          ctl.op = ffsa_pkg::OP_FAIL;
				else                                         ctl.op = ffsa_pkg::OP_SHR_INS;
			end
			ffsa_pkg::S_EXPAND: begin
				priority if (!stat.in_range || !stat.row_free || stat.next_short) begin
					ctl.op      = ffsa_pkg::OP_FAIL;
					ctl.fail_st = ffsa_pkg::RS_NO_SPACE;
				end else if (stat.next_eq) begin
					ctl.op = ffsa_pkg::OP_EXP_CLOSE;
				end else begin
					ctl.op = ffsa_pkg::OP_EXP_TRIM;
				end
			end
			ffsa_pkg::S_MARK:       ctl.op = ffsa_pkg::OP_MARK;
			ffsa_pkg::S_MERGE_INIT: ctl.op = ffsa_pkg::OP_MERGE_INIT;
			ffsa_pkg::S_MERGE: begin
				if (stat.in_range) begin
					ctl.op = (stat.acc_free && stat.row_free)
						? ffsa_pkg::OP_MERGE : ffsa_pkg::OP_MERGE_SKIP;
				end
			end
			ffsa_pkg::S_DONE: if (!stat.out_busy) ctl.op = ffsa_pkg::OP_LOAD_OUT;
			default: ctl.op = ffsa_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/core/first_fit_segment_allocator_unit.sv =====
`timescale 1ns / 1ps

// first-fit segment allocator with coalescing
// command channel: in_valid / in_stall with cmd, seg_addr, req_size; a beat is
//   taken when in_valid is high and in_stall low. in_stall is low only while
//   the unit is idle, so one command is in flight at a time
// result channel: out_valid / out_stall with result_addr, status, used_total;
//   one result beat per command, held steady while out_stall is high. a new
//   command is taken while that beat still waits in the output register
// timing: the table is scanned one row per cycle through one read port;
//   allocate, free, shrink and expand scan up to the row of the hit, a
//   shrink or expand that changes the length also touches the next row,
//   and clean scans every segment
// table edits (split, insert, removal) shift every row behind the edit in parallel
// config: cfg_we with cfg_wdata writes region_bytes and rebuilds the table as
//   one unallocated segment; write only while idle
// reset: region 4096 bytes, one unallocated segment, used bytes zero, no
//   result pending

module first_fit_segment_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ffsa_pkg::ADDR_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ffsa_pkg::CMD_W-1:0]  cmd,
	input  logic [ffsa_pkg::ADDR_W-1:0] seg_addr,
	input  logic [ffsa_pkg::ADDR_W-1:0] req_size,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ffsa_pkg::ADDR_W-1:0] result_addr,
	output logic [1:0]                  status,
	output logic [ffsa_pkg::ADDR_W-1:0] used_total
);

	// command and status between sequencer and table
	ffsa_pkg::ctl_cmd_t ctl;
	ffsa_pkg::dp_stat_t stat;

	ffsa_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	ffsa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.seg_addr    (seg_addr),
		.req_size    (req_size),
		.ctl         (ctl),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_addr (result_addr),
		.status      (status),
		.used_total  (used_total)
	);

endmodule
